// File: hw/rtl/ukli_pkg.sv
`default_nettype none
package ukli_pkg;

	localparam int MAX_KNOTS = 64;
	localparam int JOINTS    = 6;
	localparam int FRAC_BITS = 16;

	localparam int TIME_W  = 32;
	localparam int VALUE_W = 32;
	localparam int SEG_W   = 6;
	localparam int KNOT_W  = 6;
	localparam int JOINT_W = 4;

	localparam int TABLE_DEPTH = MAX_KNOTS * JOINTS;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// dt * segment count, and the quotient of (dt * nseg << FRAC_BITS) / duration
	localparam int NUMER_W   = TIME_W + SEG_W;
	localparam int QUOT_W    = SEG_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(QUOT_W);

	// (xf - xi) * fraction
	localparam int DIFF_W = VALUE_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam int CFG_IDX_W = 2;

	localparam logic [SEG_W-1:0] MAX_SEG = SEG_W'(MAX_KNOTS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIN_ORIGIN    = 2'd0,
		CFG_SPAN_DURATION = 2'd1,
		CFG_SEGMENT_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_QUERY,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [ADDR_W-1:0]    addr;
		logic [VALUE_W-1:0]   data;
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] win_origin;
		logic [TIME_W-1:0] span_duration;
		logic [SEG_W-1:0]  segment_count;
	} cfg_t;

	typedef struct packed {
		logic [JOINT_W-1:0] joint;
		logic [VALUE_W-1:0] position;
		logic               oow;
		logic               last;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_START,
		BK_DIV,
		BK_SETUP,
		BK_RD,
		BK_PROD,
		BK_OUT
	} back_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/ukli_front.sv
`default_nettype none
module ukli_front
	import ukli_pkg::*;
(
	input  wire logic                      push,
	output      logic                      full,
	input  wire logic                      opcode,
	input  wire logic [KNOT_W-1:0]         knot_index,
	input  wire logic [JOINT_W-1:0]        joint_index,
	input  wire logic signed [VALUE_W-1:0] knot_value,
	input  wire logic [TIME_W-1:0]         query_time,
	input  wire cfg_t                      cfg,
	output      logic                      fifo_push,
	output      cmd_t                      fifo_data,
	input  wire logic                      fifo_full
);

	logic              load_ok;
	logic [TIME_W:0]   win_end;
	logic              oow;
	logic [ADDR_W-1:0] load_addr;

	assign full = fifo_full;

	assign load_ok = (int'(knot_index) < MAX_KNOTS) && (int'(joint_index) < JOINTS);
	assign load_addr = ADDR_W'(knot_index) * ADDR_W'(JOINTS) + ADDR_W'(joint_index);

	// window end taken without wrap
	assign win_end = {1'b0, cfg.win_origin} + {1'b0, cfg.span_duration};
	assign oow = (query_time < cfg.win_origin) || ({1'b0, query_time} > win_end);

	always_comb begin
		fifo_data = '0;
		if (opcode == 1'b0) begin
			fifo_data.kind = CMD_LOAD;
			fifo_data.addr = load_addr;
			fifo_data.data = knot_value;
		end else if (oow) begin
			fifo_data.kind = CMD_ERROR;
		end else begin
			fifo_data.kind = CMD_QUERY;
			fifo_data.data = query_time - cfg.win_origin;
		end
	end

	// loads aimed outside the table are taken and dropped
	assign fifo_push = push && !fifo_full && (opcode == 1'b1 || load_ok);

endmodule
`default_nettype wire

// File: hw/rtl/ukli_cmd_fifo.sv
`default_nettype none
module ukli_cmd_fifo
	import ukli_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output      logic full,
	input  wire logic pop,
	output      cmd_t pop_data,
	output      logic valid
);

	cmd_t                 entry_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wptr_q;
	logic [CMD_PTR_W-1:0] rptr_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = cnt_q == CMD_CNT_W'(CMD_DEPTH);
	assign valid    = cnt_q != '0;
	assign pop_data = entry_q[rptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wptr_q] <= push_data;
	end

endmodule
`default_nettype wire

// File: hw/rtl/ukli_divider.sv
`default_nettype none
module ukli_divider
	import ukli_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [NUMER_W-1:0] numer,
	input  wire logic [TIME_W-1:0]  denom,
	output      logic [QUOT_W-1:0]  quotient,
	output      logic               done
);

	// Restoring division of (numer << FRAC_BITS) / denom, one quotient bit per cycle.
	// numer < denom << SEG_W, so the quotient fits in QUOT_W bits.
	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    rem_q;
	logic [QUOT_W-1:0]    sh_q;
	logic [TIME_W:0]      trial;
	logic [TIME_W:0]      diff;
	logic                 ge;

	assign trial    = {rem_q, sh_q[QUOT_W-1]};
	assign diff     = trial - {1'b0, denom};
	assign ge       = trial >= {1'b0, denom};
	assign quotient = sh_q;
	assign done     = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(QUOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer[NUMER_W-1:SEG_W];
			sh_q  <= {numer[SEG_W-1:0], {FRAC_BITS{1'b0}}};
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
			sh_q  <= {sh_q[QUOT_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/ukli_back.sv
`default_nettype none
module ukli_back
	import ukli_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output      logic cmd_pop,
	output      res_t res,
	output      logic res_empty,
	input  wire logic res_pop
);

	back_state_t state_q;
	back_state_t state_d;

	// knot table
	logic [VALUE_W-1:0] mem [TABLE_DEPTH];
	logic [VALUE_W-1:0] rd_a_q;
	logic [VALUE_W-1:0] rd_b_q;
	logic               mem_we;
	logic               rd_en;

	logic [TIME_W-1:0]    dt_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    step_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [JOINT_W-1:0]   j_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [SEG_W-1:0]     nseg;
	logic                 dur_zero;
	logic                 div_start;
	logic                 div_done;
	logic [QUOT_W-1:0]    div_quot;
	logic [NUMER_W-1:0]   div_numer;
	logic [SEG_W-1:0]     seg;
	logic                 at_end;
	logic [SEG_W-1:0]     idx;
	logic                 last_joint;

	logic signed [DIFF_W-1:0]    diff;
	logic signed [FRAC_BITS:0]   frac_s;
	logic signed [PROD_W-1:0]    prod;
	logic signed [PROD_W-1:0]    prod_sh;
	logic [VALUE_W-1:0]          pos;

	// result queue, two entries
	res_t       res_q [2];
	logic       res_wptr_q;
	logic       res_rptr_q;
	logic [1:0] res_cnt_q;
	logic       res_full;
	logic       res_push;
	res_t       res_in;
	logic       res_do_pop;

	assign nseg       = (cfg.segment_count > MAX_SEG) ? MAX_SEG : cfg.segment_count;
	assign dur_zero   = cfg.span_duration == '0;
	assign div_numer  = NUMER_W'(dt_q) * NUMER_W'(nseg);
	assign seg        = div_quot[QUOT_W-1:FRAC_BITS];
	assign at_end     = dur_zero || (seg >= nseg);
	assign idx        = at_end ? nseg : seg;
	assign last_joint = j_q == JOINT_W'(JOINTS - 1);

	assign diff    = $signed({rd_b_q[VALUE_W-1], rd_b_q}) - $signed({rd_a_q[VALUE_W-1], rd_a_q});
	assign frac_s  = $signed({1'b0, frac_q});
	assign prod    = diff * frac_s;
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign pos     = prod_sh[VALUE_W-1:0] + rd_a_q;

	assign res_full   = res_cnt_q == 2'd2;
	assign res_empty  = res_cnt_q == 2'd0;
	assign res        = res_q[res_rptr_q];
	assign res_do_pop = res_pop && !res_empty;

	ukli_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_numer),
		.denom    (cfg.span_duration),
		.quotient (div_quot),
		.done     (div_done)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && cmd.kind == CMD_QUERY)
					state_d = BK_START;
			end
			BK_START: state_d = dur_zero ? BK_SETUP : BK_DIV;
			BK_DIV: begin
				if (div_done)
					state_d = BK_SETUP;
			end
			BK_SETUP: state_d = BK_RD;
			BK_RD:    state_d = BK_PROD;
			BK_PROD:  state_d = BK_OUT;
			BK_OUT: begin
				if (!res_full)
					state_d = last_joint ? BK_IDLE : BK_RD;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		res_push  = 1'b0;
		res_in    = '0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						CMD_LOAD: begin
							mem_we  = 1'b1;
							cmd_pop = 1'b1;
						end
						CMD_QUERY: cmd_pop = 1'b1;
						CMD_ERROR: begin
							if (!res_full) begin
								res_push    = 1'b1;
								res_in.oow  = 1'b1;
								res_in.last = 1'b1;
								cmd_pop     = 1'b1;
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			BK_START: div_start = !dur_zero;
			BK_RD:    rd_en = 1'b1;
			BK_OUT: begin
				if (!res_full) begin
					res_push        = 1'b1;
					res_in.joint    = j_q;
					res_in.position = pos;
					res_in.last     = last_joint;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_SETUP)
				j_q <= '0;
			else if (res_push && state_q == BK_OUT)
				j_q <= j_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && cmd_valid && cmd.kind == CMD_QUERY)
			dt_q <= cmd.data;
		if (state_q == BK_SETUP) begin
			addr_q <= ADDR_W'(idx) * ADDR_W'(JOINTS);
			step_q <= at_end ? '0 : ADDR_W'(JOINTS);
			frac_q <= at_end ? '0 : div_quot[FRAC_BITS-1:0];
		end else if (res_push && state_q == BK_OUT) begin
			addr_q <= addr_q + 1'b1;
		end
		if (state_q == BK_PROD)
			prod_q <= prod;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[cmd.addr] <= cmd.data;
		if (rd_en) begin
			rd_a_q <= mem[addr_q];
			rd_b_q <= mem[addr_q + step_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wptr_q <= 1'b0;
			res_rptr_q <= 1'b0;
			res_cnt_q  <= 2'd0;
		end else begin
			if (res_push)
				res_wptr_q <= !res_wptr_q;
			if (res_do_pop)
				res_rptr_q <= !res_rptr_q;
			if (res_push && !res_do_pop)
				res_cnt_q <= res_cnt_q + 1'b1;
			else if (res_do_pop && !res_push)
				res_cnt_q <= res_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			res_q[res_wptr_q] <= res_in;
	end

endmodule
`default_nettype wire

// File: hw/rtl/uniform_knot_linear_interpolator.sv
// Piecewise-linear trajectory evaluator over equally spaced knots, one signed Q16.16
// value per knot and joint. Opcode 0 loads a knot value (no result); opcode 1 queries
// at a time and returns one result per joint, last set on the final one, or a single
// out_of_window result. Items enter a 4-deep command queue, one per cycle while it has
// room, and are executed in order: a load writes the knot table; an out-of-window query
// pushes its result once the result queue has room; an in-window query runs the 22-step
// restoring divider for the segment position and then a read, multiply and add pass per
// joint over the knot table. With span_duration 0 the divider is skipped.
// Results wait in a 2-entry queue; registers may be written only while the block is idle.
`default_nettype none
module uniform_knot_linear_interpolator
	import ukli_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       push,
	output      logic                       full,
	input  wire logic                       opcode,
	input  wire logic [KNOT_W-1:0]          knot_index,
	input  wire logic [JOINT_W-1:0]         joint_index,
	input  wire logic signed [VALUE_W-1:0]  knot_value,
	input  wire logic [TIME_W-1:0]          query_time,

	output      logic                       empty,
	input  wire logic                       pop,
	output      logic [JOINT_W-1:0]         joint_number,
	output      logic signed [VALUE_W-1:0]  position,
	output      logic                       out_of_window,
	output      logic                       last,

	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [TIME_W-1:0]          cfg_data
);

	cfg_t cfg_q;
	logic fifo_push;
	cmd_t fifo_in;
	logic fifo_full;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_origin    <= '0;
			cfg_q.span_duration <= TIME_W'(1);
			cfg_q.segment_count <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIN_ORIGIN:    cfg_q.win_origin    <= cfg_data;
				CFG_SPAN_DURATION: cfg_q.span_duration <= cfg_data;
				CFG_SEGMENT_COUNT: cfg_q.segment_count <= cfg_data[SEG_W-1:0];
				default: ;
			endcase
		end
	end

	ukli_front u_front (
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.knot_index  (knot_index),
		.joint_index (joint_index),
		.knot_value  (knot_value),
		.query_time  (query_time),
		.cfg         (cfg_q),
		.fifo_push   (fifo_push),
		.fifo_data   (fifo_in),
		.fifo_full   (fifo_full)
	);

	ukli_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (fifo_in),
		.full      (fifo_full),
		.pop       (cmd_pop),
		.pop_data  (cmd),
		.valid     (cmd_valid)
	);

	ukli_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign joint_number  = res.joint;
	assign position      = res.position;
	assign out_of_window = res.oow;
	assign last          = res.last;

endmodule
`default_nettype wire
